>>> rtl/ste_pkg.sv
// ----------------------------------------------------------------------------
// ste_pkg: shared types and constants of the sprite tile expander
// Holds the sprite descriptor that passes from classification to the tile
// walker, the queue status, and the tile layout helpers.
// ----------------------------------------------------------------------------
package ste_pkg;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam int unsigned ATTR_FLIPX_BIT  = 0;
  localparam int unsigned ATTR_FLIPY_BIT  = 1;
  localparam int unsigned ATTR_ENABLE_BIT = 2;
  localparam int unsigned ATTR_PRIO_BIT   = 5;
  localparam int unsigned ATTR_BLINK_BIT  = 6;

  localparam int unsigned IN_TDATA_W  = 80;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 64;

  localparam logic [5:0] ZORDER_TAB [8] = '{6'd0, 6'd1, 6'd4, 6'd5,
                                            6'd16, 6'd17, 6'd20, 6'd21};

  typedef struct packed {
    logic [15:0] tile_base;
    logic [3:0]  colour;
    logic [1:0]  size_log2;
    logic        flip_h;
    logic        flip_v;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
  } desc_t;

  typedef struct packed {
    logic              empty;
    logic              full;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

  typedef struct packed {
    logic busy;
  } back_stat_t;

  function automatic logic [2:0] size_mask(input logic [1:0] size_log2);
    logic [2:0] m;
    case (size_log2)
      2'd0:    m = 3'd0;
      2'd1:    m = 3'd1;
      2'd2:    m = 3'd3;
      2'd3:    m = 3'd7;
      default: m = 3'd0;
    endcase
    return m;
  endfunction

  function automatic logic [5:0] zorder(input logic [2:0] row, input logic [2:0] col);
    return ZORDER_TAB[col] | {ZORDER_TAB[row][4:0], 1'b0};
  endfunction

endpackage

>>> rtl/ste_front.sv
// ----------------------------------------------------------------------------
// ste_front: sprite descriptor intake and visibility check
// Accepts descriptors, drops hidden sprites and pushes the fields needed by
// the tile walker into the descriptor queue.
// ----------------------------------------------------------------------------
module ste_front (
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ste_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [ste_pkg::IN_TUSER_W-1:0]  in_tuser,
  input  ste_pkg::q_stat_t                q_stat,
  output logic                            q_push,
  output ste_pkg::desc_t                  q_desc
);
  import ste_pkg::*;

  logic [15:0] attr_word;
  logic [15:0] colour_size_word;
  logic        frame_odd;
  logic        layer_pass;
  logic        visible;

  always_comb begin
    attr_word        = in_tdata[15:0];
    colour_size_word = in_tdata[47:32];
    frame_odd        = in_tuser[0];
    layer_pass       = in_tuser[1];

    visible = attr_word[ATTR_ENABLE_BIT]
              && (!attr_word[ATTR_BLINK_BIT] || frame_odd)
              && (attr_word[ATTR_PRIO_BIT] == layer_pass);

    q_desc.tile_base = in_tdata[31:16];
    q_desc.colour    = colour_size_word[7:4];
    q_desc.size_log2 = colour_size_word[1:0];
    q_desc.flip_h    = attr_word[ATTR_FLIPX_BIT];
    q_desc.flip_v    = attr_word[ATTR_FLIPY_BIT];
    q_desc.pos_x     = in_tdata[63:48];
    q_desc.pos_y     = in_tdata[79:64];

    in_tready = !q_stat.full;
    q_push    = in_tvalid && in_tready && visible;
  end

endmodule

>>> rtl/ste_queue.sv
// ----------------------------------------------------------------------------
// ste_queue: descriptor queue
// A short register queue that decouples descriptor intake from tile walking.
// ----------------------------------------------------------------------------
module ste_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ste_pkg::desc_t   push_desc,
  input  logic             pop,
  output ste_pkg::desc_t   pop_desc,
  output ste_pkg::q_stat_t stat
);
  import ste_pkg::*;

  desc_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;
  logic               do_push;
  logic               do_pop;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] n;
    if (p == QPTR_W'(QDEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + QPTR_W'(1);
    end
    return n;
  endfunction

  always_comb begin
    stat.count = count_r;
    stat.empty = (count_r == '0);
    stat.full  = (count_r == QCNT_W'(QDEPTH));
    pop_desc   = mem_r[rd_ptr_r];

    do_push = push && !stat.full;
    do_pop  = pop && !stat.empty;

    wr_ptr_nxt = do_push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

>>> rtl/ste_back.sv
// ----------------------------------------------------------------------------
// ste_back: tile walker
// Steps through the rows and columns of one sprite, one tile command per
// cycle while the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module ste_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ste_pkg::q_stat_t                q_stat,
  input  ste_pkg::desc_t                  q_desc,
  output logic                            q_pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ste_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast,
  output ste_pkg::back_stat_t             stat
);
  import ste_pkg::*;

  logic                   busy_r, busy_nxt;
  desc_t                  desc_r, desc_nxt;
  logic [2:0]             row_r, row_nxt;
  logic [2:0]             col_r, col_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                   out_last_r, out_last_nxt;

  logic [2:0]  mask;
  logic [2:0]  cx;
  logic [2:0]  ry;
  logic [16:0] tile_code;
  logic [16:0] tile_x;
  logic [16:0] tile_y;
  logic        tile_last;
  logic        advance;
  logic        emit;
  logic        load;

  always_comb begin
    mask      = size_mask(desc_r.size_log2);
    cx        = desc_r.flip_h ? (col_r ^ mask) : col_r;
    ry        = desc_r.flip_v ? (row_r ^ mask) : row_r;
    tile_code = {1'b0, desc_r.tile_base} + {11'b0, zorder(row_r, col_r)};
    tile_x    = {1'b0, desc_r.pos_x} + {11'b0, cx, 3'b000};
    tile_y    = {1'b0, desc_r.pos_y} + {11'b0, ry, 3'b000};
    tile_last = (row_r == mask) && (col_r == mask);

    advance = !out_valid_r || out_tready;
    emit    = busy_r && advance;
    load    = !busy_r || (emit && tile_last);
    q_pop   = load && !q_stat.empty;

    busy_nxt      = busy_r;
    desc_nxt      = desc_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;

    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {7'b0, tile_y, tile_x, desc_r.flip_v, desc_r.flip_h,
                       desc_r.colour, tile_code};
      out_last_nxt  = tile_last;
      if (col_r == mask) begin
        col_nxt = '0;
        row_nxt = row_r + 3'd1;
      end else begin
        col_nxt = col_r + 3'd1;
      end
    end else if (advance) begin
      out_valid_nxt = 1'b0;
    end

    if (load) begin
      busy_nxt = !q_stat.empty;
      desc_nxt = q_desc;
      row_nxt  = '0;
      col_nxt  = '0;
    end

    out_tvalid = out_valid_r;
    out_tdata  = out_data_r;
    out_tlast  = out_last_r;
    stat.busy  = busy_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    desc_r     <= desc_nxt;
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

>>> rtl/sprite_tile_expander.sv
// ----------------------------------------------------------------------------
// sprite_tile_expander: expands sprite descriptors into 8x8 tile commands
// A visible sprite of S by S tiles (S = 1, 2, 4 or 8) gives S*S tile commands
// in row-major order, one per cycle while the output is not stalled, the last
// marked by out_tlast, so a sprite gives 1 to 64 tile commands and the tile
// walker sets the throughput. A hidden sprite is dropped in the cycle it is
// accepted and yields no transfer. A two-entry descriptor queue lets new
// descriptors be taken while the walker is still busy with an earlier sprite.
// ----------------------------------------------------------------------------
module sprite_tile_expander (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // attr_word[15:0], tile_base[31:16], colour_size_word[47:32],
  // pos_x[63:48], pos_y[79:64]
  input  logic [ste_pkg::IN_TDATA_W-1:0]  in_tdata,
  // frame_odd[0], layer_pass[1]
  input  logic [ste_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // tile_code[16:0], colour[20:17], flip_h[21], flip_v[22],
  // tile_x[39:23], tile_y[56:40], zero[63:57]
  output logic [ste_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast
);
  import ste_pkg::*;

  q_stat_t    q_stat;
  back_stat_t back_stat;
  desc_t      push_desc;
  desc_t      pop_desc;
  logic       q_push;
  logic       q_pop;

  ste_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_desc    (push_desc)
  );

  ste_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (push_desc),
    .pop       (q_pop),
    .pop_desc  (pop_desc),
    .stat      (q_stat)
  );

  ste_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_desc     (pop_desc),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .stat       (back_stat)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= QCNT_W'(QDEPTH))
    else $error("descriptor queue count exceeds its depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("descriptor pushed into a full queue");

  a_walk_open: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> back_stat.busy)
    else $error("non-final tile shown while the walker is idle");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && !q_stat.empty) |=> back_stat.busy)
    else $error("walker not busy after taking a descriptor");

endmodule

>>> dv/tb_sprite_tile_expander.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sprite_tile_expander: self-checking testbench of the sprite tile expander
// Sprite descriptors are sent over the input stream while an in-bench model
// expands each one into the tile commands it should produce. Every command
// transfer on the output stream is checked in order against that list. The
// run covers directed corner cases, random sprites under several idle
// patterns, and a long output stall that fills the descriptor queue.
// ----------------------------------------------------------------------------
module tb_sprite_tile_expander;
  import ste_pkg::*;

  localparam int unsigned STALL_LIMIT  = 3000;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned HOLD_CYCLES  = 400;

  typedef struct packed {
    logic [16:0] code;
    logic [3:0]  colour;
    logic        flip_h;
    logic        flip_v;
    logic [16:0] x;
    logic [16:0] y;
    logic        last;
  } tile_cmd_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [IN_TUSER_W-1:0]  in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;

  tile_cmd_t   pending_tiles[$];
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  int unsigned hold_req       = 0;
  int unsigned hold_left      = 0;
  int unsigned quiet_cycles   = 0;

  sprite_tile_expander u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [5:0] interleave_rc(input logic [2:0] row, input logic [2:0] col);
    logic [5:0] v;
    v = '0;
    for (int b = 0; b < 3; b++) begin
      v[2*b]   = col[b];
      v[2*b+1] = row[b];
    end
    return v;
  endfunction

  function automatic void expand_sprite(input logic [15:0] attr, input logic [15:0] base,
                                        input logic [15:0] cs, input logic [15:0] px,
                                        input logic [15:0] py, input logic odd,
                                        input logic pass);
    int unsigned side;
    int unsigned cx;
    int unsigned ry;
    tile_cmd_t   t;
    if (!attr[ATTR_ENABLE_BIT]) return;
    if (attr[ATTR_BLINK_BIT] && !odd) return;
    if (attr[ATTR_PRIO_BIT] != pass) return;
    side = 1 << cs[1:0];
    for (int unsigned row = 0; row < side; row++) begin
      for (int unsigned col = 0; col < side; col++) begin
        cx = attr[ATTR_FLIPX_BIT] ? side - 1 - col : col;
        ry = attr[ATTR_FLIPY_BIT] ? side - 1 - row : row;
        t.code   = {1'b0, base} + {11'd0, interleave_rc(3'(row), 3'(col))};
        t.colour = cs[7:4];
        t.flip_h = attr[ATTR_FLIPX_BIT];
        t.flip_v = attr[ATTR_FLIPY_BIT];
        t.x      = {1'b0, px} + 17'(8 * cx);
        t.y      = {1'b0, py} + 17'(8 * ry);
        t.last   = (row == side - 1) && (col == side - 1);
        pending_tiles.push_back(t);
      end
    end
  endfunction

  // Called and returns at a falling edge; tvalid stays high after a transfer.
  task automatic send_sprite(input logic [15:0] attr, input logic [15:0] base,
                             input logic [15:0] cs, input logic [15:0] px,
                             input logic [15:0] py, input logic odd, input logic pass);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {py, px, cs, base, attr};
    in_tuser  <= {pass, odd};
    expand_sprite(attr, base, cs, px, py, odd, pass);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [16:0] want,
                             input logic [16:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    tile_cmd_t got;
    tile_cmd_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.code   = out_tdata[16:0];
      got.colour = out_tdata[20:17];
      got.flip_h = out_tdata[21];
      got.flip_v = out_tdata[22];
      got.x      = out_tdata[39:23];
      got.y      = out_tdata[56:40];
      got.last   = out_tlast;
      if (pending_tiles.size() == 0) begin
        $display("%0t: unexpected tile command, expected none, actual %0h", $time, got);
        mismatch_count++;
      end else begin
        want = pending_tiles.pop_front();
        check_field("tile_code", want.code, got.code);
        check_field("colour", 17'(want.colour), 17'(got.colour));
        check_field("flip_h", 17'(want.flip_h), 17'(got.flip_h));
        check_field("flip_v", 17'(want.flip_v), 17'(got.flip_v));
        check_field("tile_x", want.x, got.x);
        check_field("tile_y", want.y, got.y);
        check_field("last_tile", 17'(want.last), 17'(got.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_sprite_tile_expander: done, errors");
      $finish;
    end
  end

  task automatic test_directed;
    send_idle_pct = 28;
    recv_idle_pct = 71;
    send_sprite(16'h0004, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);
    send_sprite(16'h0004, 16'h1234, 16'h0051, 16'h000a, 16'h0014, 1'b0, 1'b0);
    send_sprite(16'h0005, 16'h0100, 16'h0062, 16'h0020, 16'h0040, 1'b0, 1'b0);
    send_sprite(16'h0006, 16'h0200, 16'h0073, 16'h0100, 16'h0080, 1'b1, 1'b0);
    send_sprite(16'h0007, 16'hffff, 16'h00f3, 16'hffff, 16'hffff, 1'b0, 1'b0);
    send_sprite(16'h0004, 16'h0000, 16'h0003, 16'h0000, 16'h0000, 1'b1, 1'b0);
    send_sprite(16'h0000, 16'h5555, 16'h0003, 16'h1111, 16'h2222, 1'b1, 1'b0);
    send_sprite(16'h0044, 16'h0300, 16'h0011, 16'h0030, 16'h0030, 1'b0, 1'b0);
    send_sprite(16'h0044, 16'h0300, 16'h0011, 16'h0030, 16'h0030, 1'b1, 1'b0);
    send_sprite(16'h0024, 16'h0400, 16'h0021, 16'h0001, 16'h0002, 1'b0, 1'b0);
    send_sprite(16'h0004, 16'h0400, 16'h0021, 16'h0001, 16'h0002, 1'b0, 1'b1);
    send_sprite(16'h0024, 16'h0500, 16'h0082, 16'h7fff, 16'h8000, 1'b0, 1'b1);
    send_sprite(16'hffff, 16'haaaa, 16'hffff, 16'hfff8, 16'h0007, 1'b1, 1'b1);
    send_sprite(16'hff9b, 16'h0600, 16'hff0d, 16'h0050, 16'h0060, 1'b1, 1'b0);
    send_sprite(16'hff9f, 16'h0600, 16'hff0d, 16'h0050, 16'h0060, 1'b0, 1'b0);
    send_sprite(16'h0064, 16'hfffe, 16'h00a0, 16'hfffe, 16'h0000, 1'b1, 1'b1);
    send_sprite(16'h0001, 16'h0700, 16'h0001, 16'h0000, 16'h0000, 1'b1, 1'b0);
    send_sprite(16'h0004, 16'h0000, 16'h0003, 16'h0000, 16'h0000, 1'b0, 1'b0);
  endtask

  // Most sprites are built to be visible so that the tile walk is exercised.
  task automatic test_random(input int unsigned n_items, input int unsigned snd_pct,
                             input int unsigned rcv_pct);
    logic [15:0] attr;
    logic [15:0] cs;
    logic        odd;
    logic        pass;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    for (int unsigned i = 0; i < n_items; i++) begin
      attr = 16'($urandom);
      cs   = 16'($urandom);
      odd  = 1'($urandom_range(1));
      pass = 1'($urandom_range(1));
      if ($urandom_range(99) < 75) begin
        attr[ATTR_ENABLE_BIT] = 1'b1;
        attr[ATTR_PRIO_BIT]   = pass;
        if (!odd) attr[ATTR_BLINK_BIT] = 1'b0;
      end
      cs[1:0] = ($urandom_range(99) < 8) ? 2'd3 : 2'($urandom_range(2));
      send_sprite(attr, 16'($urandom), cs, 16'($urandom), 16'($urandom), odd, pass);
    end
  endtask

  // The receiver stalls for a long stretch while 4x4 sprites keep coming.
  task automatic test_backpressure;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req <= HOLD_CYCLES;
    for (int unsigned i = 0; i < 12; i++) begin
      send_sprite(16'h0004, 16'($urandom), {8'h00, 4'($urandom), 4'h2},
                  16'($urandom), 16'($urandom), 1'($urandom_range(1)), 1'b0);
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed;
    test_random(135, 28, 71);
    test_random(135, 71, 28);
    test_backpressure;
    test_random(130, 0, 0);
    in_tvalid <= 1'b0;
    while (pending_tiles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_sprite_tile_expander: done, clean");
    end else begin
      $display("tb_sprite_tile_expander: done, errors");
    end
    $finish;
  end

endmodule
